>>> hw/rtl/brb_pkg.sv
// brb_pkg: shared constants and types for the byte ring buffer
// depends on nothing; used by byte_ring_buffer_core and tb_byte_ring_buffer_core
`timescale 1ns / 1ps

package brb_pkg;

	// store geometry
	localparam int unsigned DEPTH  = 1024;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	// count and capacity width, fixed by the register and result fields
	localparam int unsigned CNT_W = 11;

	// stream and register port widths
	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 56;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	// capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

	// register index of the capacity register
	localparam logic REG_CAPACITY = 1'b0;

	// request codes
	typedef enum logic [1:0] {
		REQ_SUPPLY  = 2'd0,
		REQ_CONSUME = 2'd1,
		REQ_QUERY   = 2'd2
	} req_t;

	// control of an item between acceptance and the result register
	typedef struct packed {
		logic is_consume;
		logic accepted;
		logic eob;
	} s1_ctrl_t;

	// clamp a raw capacity to 1..DEPTH
	function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] res;
		begin
			res = raw;
			if (raw == '0) begin
				res = CNT_W'(1);
			end else if ({1'b0, raw} > (CNT_W+1)'(DEPTH)) begin
				res = CNT_W'(DEPTH);
			end
			return res;
		end
	endfunction

endpackage

>>> hw/rtl/brb_ram.sv
// brb_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`timescale 1ns / 1ps

module brb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/byte_ring_buffer_core.sv
// byte_ring_buffer_core: byte ring buffer with free/used counts per beat
// depends on brb_pkg and brb_ram
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  s       | in        | s_tvalid/s_tready  | s_tdata (req_type, data_in), s_tlast (end_of_block)
//  m       | out       | m_tvalid/m_tready  | m_tdata (counts, data_out), m_tlast (block_end)
//  apb     | in        | psel/penable/pready| paddr, pwdata, prdata (capacity)
//
//  one beat per cycle sustained while the result stream takes each beat; a beat passes stage 1,
//  with the registered read of the byte store, and then the result register
//  indices update at acceptance; counts are taken from the indices while the item sits in stage 1
//  a stalled result register holds the stage behind it and drops s_tready
//  arst_n clears indices, flag and valid bits and sets the reset capacity; the store needs no clearing

module byte_ring_buffer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [brb_pkg::S_DATA_W-1:0]    s_tdata,  // [1:0] req_type, [9:2] data_in
	input  logic                            s_tlast,  // end_of_block
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] data_out, [8] accepted, [19:9] free_count, [30:20] free_contiguous,
	// [41:31] used_count, [52:42] used_contiguous
	output logic [brb_pkg::M_DATA_W-1:0]    m_tdata,
	output logic                            m_tlast,  // block_end
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [brb_pkg::PADDR_W-1:0]     paddr,
	input  logic [brb_pkg::PDATA_W-1:0]     pwdata,
	output logic [brb_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int unsigned AW = brb_pkg::ADDR_W;
	localparam int unsigned CW = brb_pkg::CNT_W;

	// ring state
	logic [AW-1:0] wr_idx_q, rd_idx_q;
	logic          last_supply_q;
	logic [CW-1:0] capacity_q, cap_q;

	// pipeline
	logic                v_s1;
	brb_pkg::s1_ctrl_t   ctrl_s1;
	logic                out_valid_q;
	logic [brb_pkg::M_DATA_W-1:0] out_data_q;
	logic                out_last_q;

	// input unpack
	logic [1:0] req_type;
	logic [7:0] data_in;
	assign req_type = s_tdata[1:0];
	assign data_in  = s_tdata[9:2];

	// handshakes
	logic s1_adv, in_acc, cfg_wr;
	assign s1_adv   = v_s1 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 || s1_adv;
	assign in_acc   = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready
	                  && (paddr[2] == brb_pkg::REG_CAPACITY);

	// register read
	assign prdata = (paddr[2] == brb_pkg::REG_CAPACITY)
	                ? brb_pkg::PDATA_W'(capacity_q) : '0;

	// ring status
	logic idx_eq, is_empty, is_full;
	assign idx_eq   = (wr_idx_q == rd_idx_q);
	assign is_empty = idx_eq && !last_supply_q;
	assign is_full  = idx_eq && last_supply_q;

	// index successors, wrapping at the capacity
	logic [CW-1:0] wr_inc, rd_inc;
	logic [AW-1:0] wr_next, rd_next;
	assign wr_inc  = CW'(wr_idx_q) + CW'(1);
	assign rd_inc  = CW'(rd_idx_q) + CW'(1);
	assign wr_next = (wr_inc >= cap_q) ? '0 : wr_inc[AW-1:0];
	assign rd_next = (rd_inc >= cap_q) ? '0 : rd_inc[AW-1:0];

	// request decode
	logic do_supply, do_consume, item_ok;
	always_comb begin
		do_supply  = 1'b0;
		do_consume = 1'b0;
		item_ok    = 1'b1;
		unique case (req_type)
			brb_pkg::REQ_SUPPLY: begin
				do_supply = !is_full;
				item_ok   = !is_full;
			end
			brb_pkg::REQ_CONSUME: begin
				do_consume = !is_empty;
				item_ok    = !is_empty;
			end
			default: begin
				item_ok = 1'b1;
			end
		endcase
	end

	// byte store
	logic [7:0] rd_byte;
	brb_ram #(
		.WIDTH (8),
		.DEPTH (brb_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (in_acc && do_supply),
		.waddr (wr_idx_q),
		.wdata (data_in),
		.re    (in_acc && do_consume),
		.raddr (rd_idx_q),
		.rdata (rd_byte)
	);

	// index, flag and capacity update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q      <= '0;
			rd_idx_q      <= '0;
			last_supply_q <= 1'b0;
			capacity_q    <= brb_pkg::CAP_RESET;
			cap_q         <= brb_pkg::clamp_cap(brb_pkg::CAP_RESET);
		end else if (cfg_wr) begin
			wr_idx_q      <= '0;
			rd_idx_q      <= '0;
			last_supply_q <= 1'b0;
			capacity_q    <= pwdata[CW-1:0];
			cap_q         <= brb_pkg::clamp_cap(pwdata[CW-1:0]);
		end else if (in_acc && do_supply) begin
			wr_idx_q      <= wr_next;
			last_supply_q <= 1'b1;
		end else if (in_acc && do_consume) begin
			last_supply_q <= 1'b0;
			if (rd_next == wr_idx_q) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
			end else begin
				rd_idx_q <= rd_next;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctrl_s1.is_consume <= do_consume;
			ctrl_s1.accepted   <= item_ok;
			ctrl_s1.eob        <= s_tlast;
		end
	end

	// counts from the post-item indices
	logic [CW-1:0] wr_ext, rd_ext;
	logic [CW-1:0] free_count, free_contig, used_count, used_contig;
	assign wr_ext = CW'(wr_idx_q);
	assign rd_ext = CW'(rd_idx_q);

	always_comb begin
		if (is_empty) begin
			free_count = cap_q;
		end else if (rd_ext >= wr_ext) begin
			free_count = rd_ext - wr_ext;
		end else begin
			free_count = rd_ext + cap_q - wr_ext;
		end

		if (rd_ext < wr_ext || is_empty) begin
			free_contig = cap_q - wr_ext;
		end else begin
			free_contig = rd_ext - wr_ext;
		end

		if (is_full) begin
			used_count = cap_q;
		end else if (wr_ext >= rd_ext) begin
			used_count = wr_ext - rd_ext;
		end else begin
			used_count = wr_ext + cap_q - rd_ext;
		end

		if (wr_ext < rd_ext || is_full) begin
			used_contig = cap_q - rd_ext;
		end else begin
			used_contig = wr_ext - rd_ext;
		end
	end

	// result beat assembly
	logic [7:0] data_out;
	logic [brb_pkg::M_DATA_W-1:0] res_data;
	assign data_out = (ctrl_s1.is_consume) ? rd_byte : 8'd0;
	assign res_data = {3'b000, used_contig, used_count, free_contig, free_count,
	                   ctrl_s1.accepted, data_out};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= res_data;
			out_last_q <= ctrl_s1.eob;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// indices stay inside the active capacity
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ext < cap_q) && (rd_ext < cap_q))
		else $error("ring index beyond capacity");

	// an empty ring always sits at index zero
	a_empty_home: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty |-> (wr_idx_q == '0))
		else $error("empty ring not rewound");

	// free and used add up to the capacity whenever stage 1 holds an item
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((CW+1)'(free_count) + (CW+1)'(used_count) == (CW+1)'(cap_q)))
		else $error("free plus used differs from capacity");

	// a rejected beat returns a zero byte
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
		else $error("rejected beat carries data");
`endif

endmodule

>>> tb/tb_byte_ring_buffer_core.sv
// tb_byte_ring_buffer_core: self-checking bench for the byte ring buffer core
// drives the input stream and the register port, predicts every result beat in place
// depends on brb_pkg and byte_ring_buffer_core
`timescale 1ns / 1ps

module tb_byte_ring_buffer_core;

	// request code outside the defined set, handled as a query
	localparam logic [1:0] REQ_UNDEFINED = 2'd3;
	// byte addresses on the register port
	localparam logic [brb_pkg::PADDR_W-1:0] CAP_ADDR      = {brb_pkg::REG_CAPACITY, 2'b00};
	localparam logic [brb_pkg::PADDR_W-1:0] UNMAPPED_ADDR = {~brb_pkg::REG_CAPACITY, 2'b00};
	// cycles to let pass after the last result before touching the register
	localparam int SETTLE_CYCLES = 6;
	// receiver hold-off length for the backpressure test
	localparam int LONG_STALL = 64;
	// watchdog
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [7:0]                data_out;
		logic                      accepted;
		logic [brb_pkg::CNT_W-1:0] free_count;
		logic [brb_pkg::CNT_W-1:0] free_contig;
		logic [brb_pkg::CNT_W-1:0] used_count;
		logic [brb_pkg::CNT_W-1:0] used_contig;
		logic                      block_end;
	} ring_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [brb_pkg::S_DATA_W-1:0] s_tdata = '0;  // [1:0] req_type, [9:2] data_in
	logic                         s_tlast = 1'b0; // end_of_block
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	// [7:0] data_out, [8] accepted, [19:9] free_count, [30:20] free_contiguous,
	// [41:31] used_count, [52:42] used_contiguous
	logic [brb_pkg::M_DATA_W-1:0] m_tdata;
	logic                         m_tlast;        // block_end
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [brb_pkg::PADDR_W-1:0]  paddr = '0;
	logic [brb_pkg::PDATA_W-1:0]  pwdata = '0;
	logic [brb_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	// shadow copy of the ring
	logic [7:0]                ring_mem [brb_pkg::DEPTH];
	int unsigned               wr_pos = 0;
	int unsigned               rd_pos = 0;
	bit                        moved_in_last = 1'b0;
	logic [brb_pkg::CNT_W-1:0] cap_reg = brb_pkg::CAP_RESET;

	ring_result_t pending_results [$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int stall_orders = 0;
	int stall_taken = 0;
	int stall_left = 0;
	int cycles = 0;
	int mismatches = 0;
	int beats_in = 0;
	int results_checked = 0;
	int rejects_seen = 0;
	int full_seen = 0;
	int cap_writes = 0;

	byte_ring_buffer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	// ring behavior for one beat; updates the shadow state
	task automatic predict_ring(input logic [1:0] req, input logic [7:0] din, input logic eob,
			output ring_result_t r);
		int unsigned cap;
		bit empty;
		bit full;
		cap = (cap_reg == '0) ? 1
			: ((cap_reg > brb_pkg::DEPTH) ? brb_pkg::DEPTH : cap_reg);
		if (wr_pos >= cap || rd_pos >= cap) begin
			wr_pos = 0;
			rd_pos = 0;
			moved_in_last = 1'b0;
		end
		r.data_out = 8'h00;
		r.accepted = 1'b1;
		r.block_end = eob;
		empty = (wr_pos == rd_pos) && !moved_in_last;
		full = (wr_pos == rd_pos) && moved_in_last;
		case (req)
			brb_pkg::REQ_SUPPLY: begin
				if (full) begin
					r.accepted = 1'b0;
				end else begin
					ring_mem[wr_pos] = din;
					wr_pos = (wr_pos + 1 >= cap) ? 0 : wr_pos + 1;
					moved_in_last = 1'b1;
				end
			end
			brb_pkg::REQ_CONSUME: begin
				if (empty) begin
					r.accepted = 1'b0;
				end else begin
					r.data_out = ring_mem[rd_pos];
					rd_pos = (rd_pos + 1 >= cap) ? 0 : rd_pos + 1;
					moved_in_last = 1'b0;
					// drained ring restarts at the bottom
					if (rd_pos == wr_pos) begin
						rd_pos = 0;
						wr_pos = 0;
					end
				end
			end
			default: ;
		endcase
		empty = (wr_pos == rd_pos) && !moved_in_last;
		full = (wr_pos == rd_pos) && moved_in_last;
		r.free_count = brb_pkg::CNT_W'(empty ? cap : ((rd_pos >= wr_pos) ? rd_pos - wr_pos
			: rd_pos + cap - wr_pos));
		r.free_contig = brb_pkg::CNT_W'((rd_pos < wr_pos || empty) ? cap - wr_pos
			: rd_pos - wr_pos);
		r.used_count = brb_pkg::CNT_W'(full ? cap : ((wr_pos >= rd_pos) ? wr_pos - rd_pos
			: wr_pos + cap - rd_pos));
		r.used_contig = brb_pkg::CNT_W'((wr_pos < rd_pos || full) ? cap - rd_pos
			: wr_pos - rd_pos);
	endtask

	task automatic compare_result(input ring_result_t got, input ring_result_t want);
		if (got.data_out !== want.data_out)
			report_mismatch("data_out", got.data_out, want.data_out);
		if (got.accepted !== want.accepted)
			report_mismatch("accepted", got.accepted, want.accepted);
		if (got.free_count !== want.free_count)
			report_mismatch("free_count", got.free_count, want.free_count);
		if (got.free_contig !== want.free_contig)
			report_mismatch("free_contiguous", got.free_contig, want.free_contig);
		if (got.used_count !== want.used_count)
			report_mismatch("used_count", got.used_count, want.used_count);
		if (got.used_contig !== want.used_contig)
			report_mismatch("used_contiguous", got.used_contig, want.used_contig);
		if (got.block_end !== want.block_end)
			report_mismatch("block_end", got.block_end, want.block_end);
	endtask

	// monitor: register accesses, accepted input beats and result beats
	always @(posedge clk) begin
		ring_result_t want;
		ring_result_t got;
		if (arst_n) begin
			if (psel && penable && pready && (paddr >> 2) == brb_pkg::REG_CAPACITY) begin
				if (pwrite) begin
					// a capacity write empties the ring
					cap_reg = pwdata[brb_pkg::CNT_W-1:0];
					wr_pos = 0;
					rd_pos = 0;
					moved_in_last = 1'b0;
					cap_writes++;
				end else if (prdata !== brb_pkg::PDATA_W'(cap_reg)) begin
					report_mismatch("capacity readback", prdata, cap_reg);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_ring(s_tdata[1:0], s_tdata[9:2], s_tlast, want);
				pending_results.push_back(want);
				beats_in++;
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result beat with nothing pending", 1, 0);
				end else begin
					want = pending_results.pop_front();
					got.data_out = m_tdata[7:0];
					got.accepted = m_tdata[8];
					got.free_count = m_tdata[19:9];
					got.free_contig = m_tdata[30:20];
					got.used_count = m_tdata[41:31];
					got.used_contig = m_tdata[52:42];
					got.block_end = m_tlast;
					compare_result(got, want);
					results_checked++;
					if (want.accepted == 1'b0) rejects_seen++;
					if (want.free_count == '0) full_seen++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_orders != stall_taken) begin
			stall_taken = stall_orders;
			stall_left = LONG_STALL;
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// offer one beat, with an occasional gap first, and wait for acceptance
	task automatic send_beat(input logic [1:0] req, input logic [7:0] din, input logic eob);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= brb_pkg::S_DATA_W'({din, req});
		s_tlast <= eob;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop offering and wait until every result has come out
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register access, setup then access phase; psel is left high
	task automatic apb_access(input logic wr, input logic [brb_pkg::PADDR_W-1:0] addr,
			input logic [brb_pkg::PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// write a register once idle, then read capacity back
	task automatic set_capacity(input logic [brb_pkg::PADDR_W-1:0] addr,
			input logic [brb_pkg::PDATA_W-1:0] value);
		drain_pipeline();
		apb_access(1'b1, addr, value);
		apb_access(1'b0, CAP_ADDR, '0);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// extremes, every request code and the corner cases of the ring
	task automatic test_directed();
		// reset capacity, empty ring
		send_beat(brb_pkg::REQ_QUERY, 8'h00, 1'b0);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b1);
		send_beat(REQ_UNDEFINED, 8'hFF, 1'b0);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h00, 1'b0);
		send_beat(brb_pkg::REQ_SUPPLY, 8'hFF, 1'b1);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b0);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b1);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b0);
		// two-byte ring: full, reject, wrap
		set_capacity(CAP_ADDR, 32'd2);
		send_beat(brb_pkg::REQ_SUPPLY, 8'hA5, 1'b0);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h5A, 1'b1);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h3C, 1'b0);
		send_beat(brb_pkg::REQ_QUERY, 8'h00, 1'b1);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b0);
		send_beat(brb_pkg::REQ_SUPPLY, 8'hC3, 1'b0);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b0);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b1);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b0);
		// zero capacity behaves as one byte
		set_capacity(CAP_ADDR, 32'd0);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h81, 1'b0);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h18, 1'b1);
		send_beat(brb_pkg::REQ_CONSUME, 8'h00, 1'b0);
		send_beat(brb_pkg::REQ_QUERY, 8'h00, 1'b0);
		// write to an address past the register list is ignored
		set_capacity(UNMAPPED_ADDR, 32'd7);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h42, 1'b0);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h24, 1'b0);
		// oversized capacity clamps to the full store
		set_capacity(CAP_ADDR, 32'h7FF);
		send_beat(brb_pkg::REQ_QUERY, 8'h00, 1'b1);
		send_beat(brb_pkg::REQ_SUPPLY, 8'h7E, 1'b0);
	endtask

	// fill the whole store, hit full, then consume twenty bytes and supply twenty more
	task automatic test_full_ring();
		set_capacity(CAP_ADDR, brb_pkg::PDATA_W'(brb_pkg::DEPTH));
		repeat (brb_pkg::DEPTH)
			send_beat(brb_pkg::REQ_SUPPLY, 8'($urandom_range(255)), 1'($urandom_range(1)));
		send_beat(brb_pkg::REQ_SUPPLY, 8'($urandom_range(255)), 1'b1);
		repeat (20)
			send_beat(brb_pkg::REQ_CONSUME, 8'($urandom_range(255)), 1'($urandom_range(1)));
		repeat (20)
			send_beat(brb_pkg::REQ_SUPPLY, 8'($urandom_range(255)), 1'($urandom_range(1)));
		send_beat(brb_pkg::REQ_QUERY, 8'($urandom_range(255)), 1'b0);
	endtask

	// random mix of requests at one capacity, junk in the unused register bits
	task automatic test_random_traffic(input logic [brb_pkg::CNT_W-1:0] cap, input int beats);
		int supply_pct;
		int pick;
		logic [1:0] req;
		set_capacity(CAP_ADDR, {21'($urandom()), cap});
		supply_pct = $urandom_range(30, 70);
		repeat (beats) begin
			pick = $urandom_range(99);
			if (pick < supply_pct) req = brb_pkg::REQ_SUPPLY;
			else if (pick < 90) req = brb_pkg::REQ_CONSUME;
			else if (pick < 95) req = brb_pkg::REQ_QUERY;
			else req = REQ_UNDEFINED;
			send_beat(req, 8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	// long receiver hold-off while the sender keeps pushing
	task automatic test_backpressure();
		set_capacity(CAP_ADDR, 32'd8);
		stall_orders <= stall_orders + 1;
		repeat (40) begin
			send_beat(($urandom_range(3) == 0) ? brb_pkg::REQ_CONSUME : brb_pkg::REQ_SUPPLY,
				8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 11;
		sink_idle_pct = 47;
		test_directed();
		test_full_ring();

		src_idle_pct = 47;
		sink_idle_pct = 11;
		test_random_traffic(11'd1, 70);
		test_random_traffic(11'd2, 70);
		test_random_traffic(11'd3, 70);
		test_random_traffic(11'd1500, 70);
		test_random_traffic(11'd5, 70);
		test_random_traffic(11'd16, 70);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_traffic(11'd37, 70);
		test_random_traffic(11'd0, 70);
		test_random_traffic(11'd2047, 70);
		test_random_traffic(brb_pkg::CNT_W'($urandom_range(4, 64)), 70);
		test_backpressure();
		drain_pipeline();

		$display("covered %0d input beats and %0d checked results across %0d capacity writes",
			beats_in, results_checked, cap_writes);
		$display("%0d rejected requests, %0d results with the ring full", rejects_seen,
			full_seen);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/brb_pkg.sv
hw/rtl/brb_ram.sv
hw/rtl/byte_ring_buffer_core.sv
tb/tb_byte_ring_buffer_core.sv
